// ===== rtl/fbpm_pkg.sv =====
// Shared types and constants for the frame buffer pool manager.
package fbpm_pkg;

  localparam int MAX_FRAMES = 32;
  localparam int ID_W       = 5;
  localparam int CNT_W      = 6;
  localparam int CFG_DW     = 32;
  localparam int CFG_AW     = 2;

  localparam logic [CNT_W-1:0] CNT_SAT = '1;

  typedef enum logic [2:0] {
    OP_INIT       = 3'd0,
    OP_DEC_TAKE   = 3'd1,
    OP_DEC_REL    = 3'd2,
    OP_TO_DISP    = 3'd3,
    OP_DISP_TAKE  = 3'd4,
    OP_DISP_RET   = 3'd5,
    OP_RESET      = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_RANGE     = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    TAG_FREE   = 2'd0,
    TAG_QUEUED = 2'd1,
    TAG_HELD   = 2'd2
  } tag_t;

  typedef enum logic [CFG_AW-3+1:0] {
    REG_NUM_FRAMES = 1'b0
  } reg_idx_t;

  localparam logic [CFG_AW-1:0] NUM_FRAMES_ADDR = CFG_AW'(4 * REG_NUM_FRAMES);

  typedef struct packed {
    op_t             op;
    logic [ID_W-1:0] frame_id;
    logic            display;
  } fbpm_in_t;

  typedef struct packed {
    status_t          status;
    logic [ID_W-1:0]  frame_id_res;
    logic [CNT_W-1:0] free_count;
    logic [CNT_W-1:0] queued_count;
  } fbpm_out_t;

endpackage

// ===== rtl/frame_buffer_pool_manager_core.sv =====
// Frame buffer pool manager: free list, display queue and reference counts.
//
// One transaction is accepted on every clock cycle; busy stays low. The
// transaction is captured in an input register, the list and counter update
// is worked out in a single pass of logic over the register-held pool state,
// and the result is registered from that pass into out_data with out_strobe.
// The strobe lasts one cycle and the receiver cannot stall it. Frame ids
// are 5 bits and the pool holds up to 32 frames; the pool size register is
// read live by every transaction and is clamped to 1..32.
module frame_buffer_pool_manager_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  fbpm_pkg::fbpm_in_t            in_data,
  output logic                          out_strobe,
  output fbpm_pkg::fbpm_out_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fbpm_pkg::CFG_AW-1:0]   paddr,
  input  logic [fbpm_pkg::CFG_DW-1:0]   pwdata,
  output logic [fbpm_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);
  import fbpm_pkg::*;

  logic [CNT_W-1:0] num_frames_r;

  logic             item_vld_r;
  fbpm_in_t         item_r;
  logic             out_strobe_r;
  fbpm_out_t        out_data_r;

  logic [CNT_W-1:0] ref_r    [MAX_FRAMES];
  logic             shown_r  [MAX_FRAMES];
  tag_t             tag_r    [MAX_FRAMES];
  logic [ID_W-1:0]  next_r   [MAX_FRAMES];
  logic [ID_W-1:0]  prev_r   [MAX_FRAMES];
  logic [CNT_W-1:0] ref_nxt  [MAX_FRAMES];
  logic             shown_nxt[MAX_FRAMES];
  tag_t             tag_nxt  [MAX_FRAMES];
  logic [ID_W-1:0]  next_nxt [MAX_FRAMES];
  logic [ID_W-1:0]  prev_nxt [MAX_FRAMES];

  logic [ID_W-1:0]  free_head_r, free_tail_r, queue_head_r, queue_tail_r;
  logic [ID_W-1:0]  free_head_nxt, free_tail_nxt, queue_head_nxt, queue_tail_nxt;
  logic [CNT_W-1:0] free_len_r, queue_len_r, free_cnt_r, queue_cnt_r;
  logic [CNT_W-1:0] free_len_nxt, queue_len_nxt, free_cnt_nxt, queue_cnt_nxt;

  logic [CNT_W-1:0] pool_n;
  logic [ID_W-1:0]  tgt;
  logic [CNT_W-1:0] rc_rd;
  logic             sh_rd;
  tag_t             tg_rd;
  logic [ID_W-1:0]  nx_rd, pv_rd;
  logic             do_unlink, app_free, app_queue;
  logic             sel_queue;
  logic [ID_W-1:0]  lh, lt;
  logic [CNT_W-1:0] ll;
  status_t          status;
  logic [ID_W-1:0]  res_id;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign prdata = {{(CFG_DW-CNT_W){1'b0}}, num_frames_r};

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  always_comb begin
    if (num_frames_r == '0) begin
      pool_n = CNT_W'(1);
    end else if (num_frames_r > CNT_W'(MAX_FRAMES)) begin
      pool_n = CNT_W'(MAX_FRAMES);
    end else begin
      pool_n = num_frames_r;
    end
  end

  always_comb begin
    case (item_r.op)
      OP_DEC_TAKE:  tgt = free_head_r;
      OP_DISP_TAKE: tgt = queue_head_r;
      default:      tgt = item_r.frame_id;
    endcase
  end

  assign rc_rd = ref_r[tgt];
  assign sh_rd = shown_r[tgt];
  assign tg_rd = tag_r[tgt];
  assign nx_rd = next_r[tgt];
  assign pv_rd = prev_r[tgt];

  always_comb begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      ref_nxt[i]   = ref_r[i];
      shown_nxt[i] = shown_r[i];
      tag_nxt[i]   = tag_r[i];
      next_nxt[i]  = next_r[i];
      prev_nxt[i]  = prev_r[i];
    end
    free_head_nxt  = free_head_r;
    free_tail_nxt  = free_tail_r;
    queue_head_nxt = queue_head_r;
    queue_tail_nxt = queue_tail_r;
    free_len_nxt   = free_len_r;
    queue_len_nxt  = queue_len_r;
    free_cnt_nxt   = free_cnt_r;
    queue_cnt_nxt  = queue_cnt_r;
    status    = ST_OK;
    res_id    = item_r.frame_id;
    do_unlink = 1'b0;
    app_free  = 1'b0;
    app_queue = 1'b0;
    sel_queue = 1'b0;
    lh = '0;
    lt = '0;
    ll = '0;

    if (item_vld_r) begin
      if ({1'b0, item_r.frame_id} >= pool_n) begin
        status = ST_RANGE;
      end else begin
        case (item_r.op)
          OP_INIT: begin
            for (int i = 0; i < MAX_FRAMES; i++) begin
              ref_nxt[i]   = '0;
              shown_nxt[i] = 1'b0;
              tag_nxt[i]   = (CNT_W'(i) < pool_n) ? TAG_FREE : TAG_HELD;
              next_nxt[i]  = (CNT_W'(i + 1) < pool_n) ? ID_W'(i + 1) : '0;
              prev_nxt[i]  = (i >= 1 && CNT_W'(i) < pool_n) ? ID_W'(i - 1) : '0;
            end
            free_head_nxt  = '0;
            free_tail_nxt  = ID_W'(pool_n - CNT_W'(1));
            queue_head_nxt = '0;
            queue_tail_nxt = '0;
            free_len_nxt   = pool_n;
            queue_len_nxt  = '0;
            free_cnt_nxt   = pool_n;
            queue_cnt_nxt  = '0;
          end
          OP_DEC_TAKE: begin
            if (free_len_r == '0) begin
              status = ST_EMPTY;
            end else begin
              res_id         = free_head_r;
              do_unlink      = 1'b1;
              ref_nxt[tgt]   = (rc_rd != CNT_SAT) ? rc_rd + CNT_W'(1) : rc_rd;
              shown_nxt[tgt] = 1'b0;
              if (free_cnt_r != '0) free_cnt_nxt = free_cnt_r - CNT_W'(1);
            end
          end
          OP_DEC_REL: begin
            if (rc_rd == '0) begin
              status = ST_UNDERFLOW;
            end else begin
              ref_nxt[tgt] = rc_rd - CNT_W'(1);
              if (rc_rd == CNT_W'(1) && sh_rd) begin
                do_unlink = 1'b1;
                app_free  = 1'b1;
              end
            end
          end
          OP_TO_DISP: begin
            if (item_r.display) begin
              do_unlink    = 1'b1;
              app_queue    = 1'b1;
              ref_nxt[tgt] = (rc_rd != CNT_SAT) ? rc_rd + CNT_W'(1) : rc_rd;
              if (queue_cnt_r != CNT_SAT) queue_cnt_nxt = queue_cnt_r + CNT_W'(1);
            end else begin
              shown_nxt[tgt] = 1'b1;
              if (rc_rd == '0) begin
                do_unlink = 1'b1;
                app_free  = 1'b1;
              end
            end
          end
          OP_DISP_TAKE: begin
            if (queue_len_r == '0) begin
              status = ST_EMPTY;
            end else begin
              res_id    = queue_head_r;
              do_unlink = 1'b1;
              if (queue_cnt_r != '0) queue_cnt_nxt = queue_cnt_r - CNT_W'(1);
            end
          end
          OP_DISP_RET: begin
            if (rc_rd == '0) begin
              status = ST_UNDERFLOW;
            end else begin
              shown_nxt[tgt] = 1'b1;
              ref_nxt[tgt]   = rc_rd - CNT_W'(1);
              if (rc_rd == CNT_W'(1)) begin
                do_unlink = 1'b1;
                app_free  = 1'b1;
              end
            end
          end
          OP_RESET: begin
            if (queue_len_r != '0) begin
              for (int i = 0; i < MAX_FRAMES; i++) begin
                if (tag_r[i] == TAG_QUEUED) tag_nxt[i] = TAG_FREE;
              end
              if (free_len_r == '0) begin
                free_head_nxt = queue_head_r;
              end else begin
                next_nxt[free_tail_r]  = queue_head_r;
                prev_nxt[queue_head_r] = free_tail_r;
              end
              free_tail_nxt  = queue_tail_r;
              free_len_nxt   = free_len_r + queue_len_r;
              queue_len_nxt  = '0;
              queue_head_nxt = '0;
              queue_tail_nxt = '0;
            end
            free_cnt_nxt  = pool_n;
            queue_cnt_nxt = '0;
          end
          default: begin
          end
        endcase
      end
    end

    // unlink target from whichever list holds it
    if (do_unlink && (tg_rd == TAG_FREE || tg_rd == TAG_QUEUED)) begin
      sel_queue = (tg_rd == TAG_QUEUED);
      lh = sel_queue ? queue_head_r : free_head_r;
      lt = sel_queue ? queue_tail_r : free_tail_r;
      ll = sel_queue ? queue_len_r  : free_len_r;
      if (ll != '0) begin
        if (ll == CNT_W'(1)) begin
          lh = '0;
          lt = '0;
        end else if (tgt == lh) begin
          lh = nx_rd;
        end else if (tgt == lt) begin
          lt = pv_rd;
        end else begin
          next_nxt[pv_rd] = nx_rd;
          prev_nxt[nx_rd] = pv_rd;
        end
        ll = ll - CNT_W'(1);
      end
      if (sel_queue) begin
        queue_head_nxt = lh;
        queue_tail_nxt = lt;
        queue_len_nxt  = ll;
      end else begin
        free_head_nxt = lh;
        free_tail_nxt = lt;
        free_len_nxt  = ll;
      end
    end
    if (do_unlink) tag_nxt[tgt] = TAG_HELD;

    if (app_free) begin
      if (free_len_nxt == '0) begin
        free_head_nxt = tgt;
      end else begin
        next_nxt[free_tail_nxt] = tgt;
        prev_nxt[tgt]           = free_tail_nxt;
      end
      free_tail_nxt = tgt;
      free_len_nxt  = free_len_nxt + CNT_W'(1);
      tag_nxt[tgt]  = TAG_FREE;
      if (free_cnt_r != CNT_SAT) free_cnt_nxt = free_cnt_r + CNT_W'(1);
    end

    if (app_queue) begin
      if (queue_len_nxt == '0) begin
        queue_head_nxt = tgt;
      end else begin
        next_nxt[queue_tail_nxt] = tgt;
        prev_nxt[tgt]            = queue_tail_nxt;
      end
      queue_tail_nxt = tgt;
      queue_len_nxt  = queue_len_nxt + CNT_W'(1);
      tag_nxt[tgt]   = TAG_QUEUED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_frames_r <= CNT_W'(MAX_FRAMES);
      item_vld_r   <= 1'b0;
      out_strobe_r <= 1'b0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        ref_r[i]   <= '0;
        shown_r[i] <= 1'b0;
        tag_r[i]   <= TAG_FREE;
        next_r[i]  <= (i + 1 < MAX_FRAMES) ? ID_W'(i + 1) : '0;
        prev_r[i]  <= (i >= 1) ? ID_W'(i - 1) : '0;
      end
      free_head_r  <= '0;
      free_tail_r  <= ID_W'(MAX_FRAMES - 1);
      queue_head_r <= '0;
      queue_tail_r <= '0;
      free_len_r   <= CNT_W'(MAX_FRAMES);
      queue_len_r  <= '0;
      free_cnt_r   <= CNT_W'(MAX_FRAMES);
      queue_cnt_r  <= '0;
    end else begin
      if (psel && penable && pwrite && paddr == NUM_FRAMES_ADDR) begin
        num_frames_r <= pwdata[CNT_W-1:0];
      end
      item_vld_r   <= start && !busy;
      out_strobe_r <= item_vld_r;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        ref_r[i]   <= ref_nxt[i];
        shown_r[i] <= shown_nxt[i];
        tag_r[i]   <= tag_nxt[i];
        next_r[i]  <= next_nxt[i];
        prev_r[i]  <= prev_nxt[i];
      end
      free_head_r  <= free_head_nxt;
      free_tail_r  <= free_tail_nxt;
      queue_head_r <= queue_head_nxt;
      queue_tail_r <= queue_tail_nxt;
      free_len_r   <= free_len_nxt;
      queue_len_r  <= queue_len_nxt;
      free_cnt_r   <= free_cnt_nxt;
      queue_cnt_r  <= queue_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r                  <= in_data;
    out_data_r.status       <= status;
    out_data_r.frame_id_res <= res_id;
    out_data_r.free_count   <= free_cnt_nxt;
    out_data_r.queued_count <= queue_cnt_nxt;
  end

endmodule
